>>> design/rcg_pkg.sv
// Shared types and constants for the replay cache gate.
package rcg_pkg;

    typedef enum logic [1:0] {
        OP_CHECK  = 2'd0,
        OP_COMMIT = 2'd1,
        OP_REBIND = 2'd2,
        OP_BAD    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MISMATCH  = 3'd1,
        ST_SCHEMA    = 3'd2,
        ST_EXPIRED   = 3'd3,
        ST_REPLAYED  = 3'd4,
        ST_EXHAUSTED = 3'd5,
        ST_STALE     = 3'd6
    } status_t;

    localparam logic [1:0] BIND_MATCH = 2'd0;
    localparam logic [1:0] BIND_ZERO  = 2'd2;

    localparam logic [63:0] SERIAL_HALF = 64'h8000_0000_0000_0000;

    localparam logic [2:0] REG_TTL   = 3'd0;
    localparam logic [2:0] REG_SLOTS = 3'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COMPARE,
        S_CLEAR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] now_ms;
        logic [63:0] issue_ms;
        logic [63:0] frame_exp_ms;
        logic [63:0] sequence_req;
        logic [63:0] msg_id_hi;
        logic [63:0] msg_id_lo;
        logic [1:0]  binding_status;
        logic [5:0]  prep_slot;
        logic [63:0] prep_generation;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] out_generation;
        logic [5:0]  out_slot;
        logic [63:0] cache_expiry;
    } rsp_t;

    // Serial-number comparison: cand is newer than cur
    function automatic logic serial_newer(input logic [63:0] cand, input logic [63:0] cur);
        logic [63:0] d;
        d = cand - cur;
        return (d != 64'd0) && (d < SERIAL_HALF);
    endfunction

endpackage

>>> design/rcg_if.sv
// Valid/ready channel interface carrying one payload.
interface rcg_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> design/replay_cache_gate_unit.sv
// Top level of the replay cache gate.
//
//  channel  dir  transfer when         payload
//  req      in   valid && ready        rcg_pkg::req_t (op, times, ids, prep)
//  rsp      out  valid && ready        rcg_pkg::rsp_t (status, gen, slot, expiry)
//  apb      in   psel&penable&pwrite   ttl_ms at 0x0, slots_in_use at 0x4
//
// A check reads one memory word per slot in use (at most CACHE_DEPTH),
// compared by a single id/expiry comparator. Commit, rebind and early rejects
// skip the scan. Reset is asynchronous and needs no clearing pass; valid bits
// clear at once. The input is not ready while an item is in work, and a
// result holds until taken.
module replay_cache_gate_unit #(
    parameter int CACHE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    rcg_if.sink         req,
    rcg_if.source       rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [31:0] ttl_ms;
    logic [6:0]  slots_in_use;

    rcg_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .ttl_ms       (ttl_ms),
        .slots_in_use (slots_in_use)
    );

    rcg_core #(.CACHE_DEPTH(CACHE_DEPTH)) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (req.valid),
        .in_ready     (req.ready),
        .req          (req.payload),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .rsp          (rsp.payload),
        .ttl_ms       (ttl_ms),
        .slots_in_use (slots_in_use)
    );
endmodule

>>> design/rcg_cfg.sv
// APB-style configuration registers for the replay cache gate.
module rcg_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] ttl_ms,
    output logic [6:0]  slots_in_use
);
    logic [31:0] ttl_reg;
    logic [6:0]  slots_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg   <= 32'd60000;
            slots_reg <= 7'd64;
        end
        else if (wr_en)
        begin
            if (paddr == {rcg_pkg::REG_TTL[0], 2'b00})
                ttl_reg <= pwdata;
            else if (paddr == {rcg_pkg::REG_SLOTS[0], 2'b00})
                slots_reg <= pwdata[6:0];
        end
    end

    // Read mux
    always_comb
    begin
        prdata = 32'd0;
        if (paddr == {rcg_pkg::REG_TTL[0], 2'b00})
            prdata = ttl_reg;
        else if (paddr == {rcg_pkg::REG_SLOTS[0], 2'b00})
            prdata = {25'd0, slots_reg};
    end

    assign ttl_ms       = ttl_reg;
    assign slots_in_use = slots_reg;
endmodule

>>> design/rcg_core.sv
// Sequencer, cache memory and shared compare unit of the replay cache gate.
module rcg_core #(
    parameter int CACHE_DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rcg_pkg::req_t        req,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rcg_pkg::rsp_t        rsp,
    input  logic [31:0]          ttl_ms,
    input  logic [6:0]           slots_in_use
);
    localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int CW = $clog2(CACHE_DEPTH + 1);

    // Cache memory: one wide word per slot
    logic [191:0] mem [CACHE_DEPTH];
    logic [191:0] rd_data_reg;
    logic [CACHE_DEPTH-1:0] valid_reg;
    logic          valid_rd_reg;

    rcg_pkg::state_t state_reg, state_next;
    rcg_pkg::req_t   req_reg;
    rcg_pkg::rsp_t   rsp_reg, rsp_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   n_slots;
    logic            found_reg, found_next;
    logic [AW-1:0]   slot_reg, slot_next;
    logic [63:0]     last_seq_reg, gen_reg;
    logic            seq_seen_reg, bound_reg;
    logic            accept, wr_en, do_commit, do_rebind;
    logic [64:0]     ttl_sum;
    logic [63:0]     ttl_cap;
    logic            live, id_hit;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   pslot_a;

    assign in_ready  = (state_reg == rcg_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = (state_reg == rcg_pkg::S_DONE);
    assign rsp       = rsp_reg;

    // Slots in use, limited to the depth
    always_comb
    begin
        if ({25'd0, slots_in_use} < 32'(CACHE_DEPTH))
            n_slots = CW'(slots_in_use);
        else
            n_slots = CW'(CACHE_DEPTH);
    end

    assign rd_addr = idx_reg[AW-1:0];
    assign pslot_a = AW'(req_reg.prep_slot);

    // Memory read and write
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[pslot_a] <= {req_reg.msg_id_hi, req_reg.msg_id_lo, req_reg.frame_exp_ms};
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_rd_reg <= 1'b0;
        else
            valid_rd_reg <= valid_reg[rd_addr];
    end

    // Shared compare unit on the slot read last cycle
    assign live   = valid_rd_reg && (rd_data_reg[63:0] > req_reg.now_ms);
    assign id_hit = (rd_data_reg[191:128] == req_reg.msg_id_hi)
                 && (rd_data_reg[127:64] == req_reg.msg_id_lo);

    assign ttl_sum = {1'b0, req_reg.now_ms} + {33'd0, ttl_ms};
    assign ttl_cap = ttl_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : ttl_sum[63:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rcg_pkg::S_IDLE:
                if (accept)
                    state_next = rcg_pkg::S_CLEAR;
            rcg_pkg::S_CLEAR:
                // Decode cycle: prechecks resolved here
                if (rsp_next.status != rcg_pkg::ST_OK
                    || req_reg.op != rcg_pkg::OP_CHECK || n_slots == '0)
                    state_next = rcg_pkg::S_DONE;
                else
                    state_next = rcg_pkg::S_SCAN;
            rcg_pkg::S_SCAN:
                state_next = rcg_pkg::S_COMPARE;
            rcg_pkg::S_COMPARE:
                if ((live && id_hit) || idx_reg == n_slots)
                    state_next = rcg_pkg::S_DONE;
                else
                    state_next = rcg_pkg::S_COMPARE;
            rcg_pkg::S_DONE:
                if (out_ready)
                    state_next = rcg_pkg::S_IDLE;
            default:
                state_next = rcg_pkg::S_IDLE;
        endcase
    end

    // Outputs of each state
    always_comb
    begin
        rsp_next   = rsp_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        slot_next  = slot_reg;
        wr_en      = 1'b0;
        do_commit  = 1'b0;
        do_rebind  = 1'b0;
        case (state_reg)
            rcg_pkg::S_IDLE:
            begin
                idx_next   = '0;
                found_next = 1'b0;
                slot_next  = '0;
            end
            rcg_pkg::S_CLEAR:
            begin
                rsp_next = '0;
                case (req_reg.op)
                    rcg_pkg::OP_CHECK:
                        if (!bound_reg)
                            rsp_next.status = rcg_pkg::ST_MISMATCH;
                        else if ((req_reg.msg_id_hi == 64'd0 && req_reg.msg_id_lo == 64'd0)
                                 || req_reg.binding_status == rcg_pkg::BIND_ZERO)
                            rsp_next.status = rcg_pkg::ST_SCHEMA;
                        else if (req_reg.issue_ms > req_reg.now_ms
                                 || req_reg.frame_exp_ms <= req_reg.now_ms)
                            rsp_next.status = rcg_pkg::ST_EXPIRED;
                        else if (req_reg.binding_status != rcg_pkg::BIND_MATCH)
                            rsp_next.status = rcg_pkg::ST_MISMATCH;
                        else if (seq_seen_reg
                                 && !rcg_pkg::serial_newer(req_reg.sequence_req, last_seq_reg))
                            rsp_next.status = rcg_pkg::ST_REPLAYED;
                        else if (n_slots == '0)
                            rsp_next.status = rcg_pkg::ST_EXHAUSTED;
                    rcg_pkg::OP_COMMIT:
                        if (!bound_reg || req_reg.prep_generation != gen_reg
                            || 32'(req_reg.prep_slot) >= 32'(n_slots)
                            || (seq_seen_reg
                                && !rcg_pkg::serial_newer(req_reg.sequence_req, last_seq_reg)))
                            rsp_next.status = rcg_pkg::ST_STALE;
                        else
                        begin
                            wr_en     = 1'b1;
                            do_commit = 1'b1;
                        end
                    rcg_pkg::OP_REBIND:
                        if (req_reg.binding_status == rcg_pkg::BIND_ZERO)
                            rsp_next.status = rcg_pkg::ST_SCHEMA;
                        else
                            do_rebind = 1'b1;
                    default:
                        rsp_next.status = rcg_pkg::ST_SCHEMA;
                endcase
                // Slot 0 is read while in S_SCAN
                idx_next = '0;
            end
            rcg_pkg::S_SCAN:
                idx_next = CW'(1);
            rcg_pkg::S_COMPARE:
            begin
                // Entry idx_reg-1 is in the read register
                if (!live)
                begin
                    if (!found_reg)
                    begin
                        found_next = 1'b1;
                        slot_next  = AW'(idx_reg - CW'(1));
                    end
                end
                else if (id_hit)
                    rsp_next.status = rcg_pkg::ST_REPLAYED;
                if (idx_reg != n_slots)
                    idx_next = idx_reg + CW'(1);
                if (!(live && id_hit) && idx_reg == n_slots)
                begin
                    if (!found_next)
                        rsp_next.status = rcg_pkg::ST_EXHAUSTED;
                    else
                    begin
                        rsp_next.out_generation = gen_reg;
                        rsp_next.out_slot       = 6'(slot_next);
                        rsp_next.cache_expiry   = (req_reg.frame_exp_ms < ttl_cap)
                                                  ? req_reg.frame_exp_ms : ttl_cap;
                    end
                end
            end
            rcg_pkg::S_DONE:
                idx_next = idx_reg;
            default:
                idx_next = '0;
        endcase
    end

    // Control and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rcg_pkg::S_IDLE;
            valid_reg    <= '0;
            last_seq_reg <= 64'd0;
            seq_seen_reg <= 1'b0;
            bound_reg    <= 1'b0;
            gen_reg      <= 64'd0;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            slot_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            slot_reg  <= slot_next;
            if (do_commit)
            begin
                valid_reg[pslot_a] <= 1'b1;
                last_seq_reg       <= req_reg.sequence_req;
                seq_seen_reg       <= 1'b1;
                gen_reg            <= gen_reg + 64'd1;
            end
            else if (do_rebind)
            begin
                valid_reg    <= '0;
                last_seq_reg <= 64'd0;
                seq_seen_reg <= 1'b0;
                bound_reg    <= 1'b1;
                gen_reg      <= gen_reg + 64'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= req;
        rsp_reg <= rsp_next;
    end
endmodule
